/* rtl/dpfp_pkg.sv */
// ----------------------------------------------------------------------------
// dpfp_pkg
// Shared types, character codes and helpers for the device path field parser.
// ----------------------------------------------------------------------------
package dpfp_pkg;

    // Parse phases, one-hot
    typedef enum logic [8:0] {
        PH_PREFIX = 9'b000000001,
        PH_CHAN   = 9'b000000010,
        PH_COL1   = 9'b000000100,
        PH_DRIVE  = 9'b000001000,
        PH_COL2   = 9'b000010000,
        PH_BASE   = 9'b000100000,
        PH_COL3   = 9'b001000000,
        PH_LEN    = 9'b010000000,
        PH_END    = 9'b100000000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  pos;
        logic [63:0] acc;
        logic [7:0]  chan;
        logic [7:0]  drive;
        logic [63:0] base;
        logic        mismatch;
    } t_parse_state;

    typedef struct packed {
        logic        recognized;
        logic [7:0]  channel_number;
        logic [7:0]  drive_number;
        logic [63:0] base_offset;
        logic [63:0] region_length;
    } t_result;

    localparam t_parse_state PARSE_IDLE = '{
        phase:    PH_PREFIX,
        pos:      5'd0,
        acc:      64'd0,
        chan:     8'd0,
        drive:    8'd0,
        base:     64'd0,
        mismatch: 1'b0
    };

    // Configuration register indexes
    localparam logic CFG_PREFIX_CHARS  = 1'b0;
    localparam logic CFG_PREFIX_LENGTH = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [4:0] SHORT_DIGITS = 5'd2;
    localparam logic [4:0] LONG_DIGITS  = 5'd16;

    localparam logic [8:0] BASE_ALIGN_MASK = 9'h1FF;

    // Bit 4 set when c is a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

/* rtl/dpfp_step.sv */
// ----------------------------------------------------------------------------
// dpfp_step
// Next parser state for one non-terminator character.
// ----------------------------------------------------------------------------
module dpfp_step (
    input  dpfp_pkg::t_parse_state i_cur,
    input  logic [7:0]             i_char,
    input  logic [63:0]            i_prefix_chars,
    input  logic [3:0]             i_prefix_len,
    output dpfp_pkg::t_parse_state o_nxt
);
    import dpfp_pkg::*;

    t_parse_state st;
    logic [4:0]   dig;
    logic [63:0]  acc_shift;
    logic [4:0]   pos_inc;
    logic [7:0]   want;

    always_comb begin
        // Leave the prefix once all configured characters matched
        st = i_cur;
        if (i_cur.phase == PH_PREFIX && i_cur.pos >= {1'b0, i_prefix_len}) begin
            st.phase = PH_CHAN;
            st.pos   = 5'd0;
            st.acc   = 64'd0;
        end

        dig       = hex_digit(i_char);
        acc_shift = {st.acc[59:0], dig[3:0]};
        pos_inc   = st.pos + 5'd1;
        want      = i_prefix_chars[{st.pos[2:0], 3'b000} +: 8];

        o_nxt = st;
        unique case (st.phase)
            PH_PREFIX: begin
                if (i_char != want) o_nxt.mismatch = 1'b1;
                else                o_nxt.pos      = pos_inc;
            end
            PH_CHAN, PH_DRIVE, PH_BASE, PH_LEN: begin
                if (!dig[4]) begin
                    o_nxt.mismatch = 1'b1;
                end else begin
                    o_nxt.acc = acc_shift;
                    o_nxt.pos = pos_inc;
                    unique case (st.phase)
                        PH_CHAN: begin
                            if (pos_inc >= SHORT_DIGITS) begin
                                o_nxt.chan  = acc_shift[7:0];
                                o_nxt.phase = PH_COL1;
                            end
                        end
                        PH_DRIVE: begin
                            if (pos_inc >= SHORT_DIGITS) begin
                                o_nxt.drive = acc_shift[7:0];
                                o_nxt.phase = PH_COL2;
                            end
                        end
                        PH_BASE: begin
                            if (pos_inc >= LONG_DIGITS) begin
                                o_nxt.base  = acc_shift;
                                o_nxt.phase = PH_COL3;
                            end
                        end
                        default: begin
                            if (pos_inc >= LONG_DIGITS) o_nxt.phase = PH_END;
                        end
                    endcase
                end
            end
            PH_COL1, PH_COL2, PH_COL3: begin
                if (i_char != CHAR_COLON) begin
                    o_nxt.mismatch = 1'b1;
                end else begin
                    o_nxt.pos = 5'd0;
                    o_nxt.acc = 64'd0;
                    unique case (st.phase)
                        PH_COL1: o_nxt.phase = PH_DRIVE;
                        PH_COL2: o_nxt.phase = PH_BASE;
                        default: o_nxt.phase = PH_LEN;
                    endcase
                end
            end
            default: o_nxt.mismatch = 1'b1;
        endcase
    end

endmodule

/* rtl/device_path_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// device_path_field_parser_unit
// Character-stream parser for device paths of the form
//   <prefix><ch:2 hex>:<drv:2 hex>:<base:16 hex>:<len:16 hex>, zero-terminated.
// Input channel: one character per transaction (i_path_*). Every character is
// folded into the parse state in the cycle it is taken, so one character per
// cycle is sustained while o_path_ready is high. Output channel: one result
// transaction per zero byte, registered.
// The result side holds an output register and one skid entry; o_path_ready
// drops only while both hold results, i.e. when the receiver has stalled
// for a result while a second terminator arrived.
// Configuration: i_cfg_* writes prefix_chars (index 0) or prefix_length
// (index 1); always ready. Write only while no path is in flight.
// Reset clears the configuration, the parse state and both result slots.
// ----------------------------------------------------------------------------
module device_path_field_parser_unit #(
    parameter int PREFIX_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_path_valid,
    output logic        o_path_ready,
    input  logic [7:0]  i_path_char,

    output logic        o_result_valid,
    input  logic        i_result_ready,
    output logic        o_recognized,
    output logic [7:0]  o_channel_number,
    output logic [7:0]  o_drive_number,
    output logic [63:0] o_base_offset,
    output logic [63:0] o_region_length,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import dpfp_pkg::*;

    logic [63:0]  r_prefix_chars;
    logic [3:0]   r_prefix_length;
    logic [3:0]   plen;

    t_parse_state r_state, n_state, step_nxt;

    logic         r_out_valid, n_out_valid;
    t_result      r_out, n_out;
    logic         r_skid_valid, n_skid_valid;
    t_result      r_skid, n_skid;

    logic         in_fire;
    logic         push;
    logic         pop;
    logic         ok;
    t_result      new_res;

    assign o_cfg_ready  = 1'b1;
    assign o_path_ready = !r_skid_valid;
    assign in_fire      = i_path_valid && o_path_ready;
    assign push         = in_fire && (i_path_char == CHAR_NUL);
    assign pop          = r_out_valid && i_result_ready;

    // Clamp oversize prefix lengths
    assign plen = ({28'd0, r_prefix_length} > 32'(PREFIX_MAX)) ? 4'(PREFIX_MAX)
                                                               : r_prefix_length;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_chars  <= 64'd0;
            r_prefix_length <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PREFIX_CHARS:  r_prefix_chars  <= i_cfg_data;
                CFG_PREFIX_LENGTH: r_prefix_length <= i_cfg_data[3:0];
            endcase
        end
    end

    dpfp_step u_step (
        .i_cur          (r_state),
        .i_char         (i_path_char),
        .i_prefix_chars (r_prefix_chars),
        .i_prefix_len   (plen),
        .o_nxt          (step_nxt)
    );

    // Verdict for a terminator arriving now
    always_comb begin
        ok = !r_state.mismatch && (r_state.phase == PH_END) && (r_state.acc != 64'd0)
             && ((r_state.base[8:0] & BASE_ALIGN_MASK) == 9'd0);
        new_res.recognized     = ok;
        new_res.channel_number = ok ? r_state.chan  : 8'd0;
        new_res.drive_number   = ok ? r_state.drive : 8'd0;
        new_res.base_offset    = ok ? r_state.base  : 64'd0;
        new_res.region_length  = ok ? r_state.acc   : 64'd0;
    end

    // Parse state: restart on the terminator, hold once a mismatch is seen
    always_comb begin
        n_state = r_state;
        if (in_fire) begin
            if (i_path_char == CHAR_NUL)  n_state = PARSE_IDLE;
            else if (!r_state.mismatch)   n_state = step_nxt;
        end
    end

    // Output register with one skid entry behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = push;
                n_out       = new_res;
            end
        end else if (push) begin
            n_skid_valid = 1'b1;
            n_skid       = new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= PARSE_IDLE;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_result_valid   = r_out_valid;
    assign o_recognized     = r_out.recognized;
    assign o_channel_number = r_out.channel_number;
    assign o_drive_number   = r_out.drive_number;
    assign o_base_offset    = r_out.base_offset;
    assign o_region_length  = r_out.region_length;

endmodule

/* tb/sv/tb_device_path_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_device_path_field_parser_unit
// Self-checking bench for the device path field parser. Paths go in one
// character per transaction; every terminator yields one result transaction,
// checked field by field against a typed answer or a cycle-free model of
// the parse kept here. A directed table covers the corner paths, then random
// well-formed, damaged and junk paths run under changing prefix settings,
// with random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_device_path_field_parser_unit;
    import dpfp_pkg::*;

    localparam int PREFIX_MAX     = 8;
    localparam int ITEM_TARGET    = 1650;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 240;

    localparam logic [7:0] CH_DIGIT0  = "0";
    localparam logic [7:0] CH_DIGIT9  = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_F = "F";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_F = "f";
    localparam logic [4:0] NOT_HEX    = 5'h10;

    localparam t_result REJECTED = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_path_valid = 1'b0;
    logic        o_path_ready;
    logic [7:0]  i_path_char = 8'd0;
    logic        o_result_valid;
    logic        i_result_ready = 1'b0;
    logic        o_recognized;
    logic [7:0]  o_channel_number;
    logic [7:0]  o_drive_number;
    logic [63:0] o_base_offset;
    logic [63:0] o_region_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_PREFIX_CHARS;
    logic [63:0] i_cfg_data = 64'd0;

    device_path_field_parser_unit #(.PREFIX_MAX(PREFIX_MAX)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parse state mirrored from the accepted character stream
    t_phase      pp_phase = PH_PREFIX;
    logic [4:0]  pp_pos   = '0;
    logic [63:0] pp_acc   = '0;
    logic [7:0]  pp_chan  = '0;
    logic [7:0]  pp_drive = '0;
    logic [63:0] pp_base  = '0;
    logic        pp_bad   = 1'b0;
    logic [63:0] seen_prefix_chars = '0;
    logic [3:0]  seen_prefix_len   = '0;

    t_result results_due[$];     // decoded paths waiting for their result transaction
    t_result typed_results[$];   // hand-written answer for the path now in flight
    logic [7:0] path_buf[$];     // characters of the next path, terminator excluded

    // Settings as last written by the driver
    logic [63:0] cur_chars = '0;
    logic [3:0]  cur_plen  = '0;

    int  mismatches = 0;
    int  results_checked = 0;
    int  recognized_seen = 0;
    int  chars_sent = 0;
    int  paths_sent = 0;
    int  cfg_writes = 0;
    int  idle_run = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_gaps_on = 1'b1;
    int  rx_hold_req = 0;
    int  rx_hold_left = 0;
    int  rx_stall_left = 0;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return 5'(c - CH_DIGIT0);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A + 8'd10);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 5'(c - CH_LOWER_A + 8'd10);
        return NOT_HEX;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return CH_DIGIT0 + 8'(v);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    // First character lands in the lowest byte
    function automatic logic [63:0] pack_prefix(input string s);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
        return r;
    endfunction

    function automatic void clear_parse();
        pp_phase = PH_PREFIX;
        pp_pos   = '0;
        pp_acc   = '0;
        pp_chan  = '0;
        pp_drive = '0;
        pp_base  = '0;
        pp_bad   = 1'b0;
    endfunction

    // Advance the mirrored parse by one accepted character
    function automatic void parse_char(input logic [7:0] c);
        logic [3:0] plen;
        logic [4:0] d;
        logic [4:0] need;
        t_result    r;
        plen = (seen_prefix_len > PREFIX_MAX) ? 4'(PREFIX_MAX) : seen_prefix_len;
        if (c == CHAR_NUL) begin
            r = REJECTED;
            if (!pp_bad && pp_phase == PH_END && pp_acc != 0 &&
                (pp_base[8:0] & BASE_ALIGN_MASK) == 9'd0)
                r = '{1'b1, pp_chan, pp_drive, pp_base, pp_acc};
            if (typed_results.size() != 0) r = typed_results.pop_front();
            results_due.push_back(r);
            clear_parse();
            return;
        end
        if (pp_bad) return;   // swallow everything up to the terminator
        if (pp_phase == PH_PREFIX && pp_pos >= 5'(plen)) begin
            pp_phase = PH_CHAN;
            pp_pos   = '0;
            pp_acc   = '0;
        end
        need = (pp_phase == PH_BASE || pp_phase == PH_LEN) ? LONG_DIGITS : SHORT_DIGITS;
        d = digit_of(c);
        case (pp_phase)
            PH_PREFIX: begin
                if (c != seen_prefix_chars[8*pp_pos[2:0] +: 8]) pp_bad = 1'b1;
                else pp_pos++;
            end
            PH_CHAN, PH_DRIVE, PH_BASE, PH_LEN: begin
                if (d[4]) begin
                    pp_bad = 1'b1;
                end else begin
                    pp_acc = {pp_acc[59:0], d[3:0]};
                    pp_pos++;
                    if (pp_pos >= need) begin
                        case (pp_phase)
                            PH_CHAN: begin
                                pp_chan  = pp_acc[7:0];
                                pp_phase = PH_COL1;
                            end
                            PH_DRIVE: begin
                                pp_drive = pp_acc[7:0];
                                pp_phase = PH_COL2;
                            end
                            PH_BASE: begin
                                pp_base  = pp_acc;
                                pp_phase = PH_COL3;
                            end
                            default: pp_phase = PH_END;
                        endcase
                    end
                end
            end
            PH_COL1, PH_COL2, PH_COL3: begin
                if (c != CHAR_COLON) begin
                    pp_bad = 1'b1;
                end else begin
                    case (pp_phase)
                        PH_COL1: pp_phase = PH_DRIVE;
                        PH_COL2: pp_phase = PH_BASE;
                        default: pp_phase = PH_LEN;
                    endcase
                    pp_pos = '0;
                    pp_acc = '0;
                end
            end
            default: pp_bad = 1'b1;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Observe every transaction at the rising edge; inputs only move on the
    // falling edge, so the sampled values are settled.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            clear_parse();
            seen_prefix_chars = '0;
            seen_prefix_len   = '0;
        end else begin
            if (o_result_valid && i_result_ready) begin
                moved = 1'b1;
                got = '{o_recognized, o_channel_number, o_drive_number,
                        o_base_offset, o_region_length};
                if (results_due.size() == 0) begin
                    $error("result transaction with no path pending");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("recognized", 64'(want.recognized), 64'(got.recognized));
                    check_field("channel_number", 64'(want.channel_number),
                                64'(got.channel_number));
                    check_field("drive_number", 64'(want.drive_number),
                                64'(got.drive_number));
                    check_field("base_offset", want.base_offset, got.base_offset);
                    check_field("region_length", want.region_length, got.region_length);
                    results_checked++;
                    if (got.recognized === 1'b1) recognized_seen++;
                end
            end
            if (i_path_valid && o_path_ready) begin
                moved = 1'b1;
                parse_char(i_path_char);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_PREFIX_CHARS) seen_prefix_chars = i_cfg_data;
                else seen_prefix_len = i_cfg_data[3:0];
            end
            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         idle_run, results_due.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus the long hold-off when requested
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            rdy = 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            rdy = 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
            rx_stall_left = $urandom_range(1, 14) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_result_ready <= rdy;
    end

    // Offer one character and hold it until taken; valid stays high on return
    task automatic put_char(input logic [7:0] c);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_path_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_path_valid <= 1'b1;
        i_path_char  <= c;
        do @(posedge i_clk); while (!o_path_ready);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_path();
        foreach (path_buf[k]) put_char(path_buf[k]);
        put_char(CHAR_NUL);
        paths_sent++;
    endtask

    // Drop valid and wait until every result is back, then let the block settle
    task automatic settle();
        i_path_valid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers back to back; valid stays high across the pair
    task automatic configure(input logic [3:0] plen, input logic [63:0] chars);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PREFIX_CHARS;
        i_cfg_data  <= chars;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_PREFIX_LENGTH;
        i_cfg_data  <= {32'($urandom), 28'($urandom), plen};
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_plen  = plen;
        cur_chars = chars;
        cfg_writes++;
    endtask

    task automatic push_hex(input logic [63:0] v, input int digits);
        for (int k = digits - 1; k >= 0; k--)
            path_buf.push_back(hex_char(v[4*k +: 4], bit'($urandom_range(0, 1))));
    endtask

    // Mostly well-formed paths with random content, some damaged, some junk
    task automatic build_path();
        int          kind;
        int          cut;
        logic [7:0]  pc;
        logic [63:0] base;
        logic [63:0] span;
        path_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            repeat ($urandom_range(0, 12)) path_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        for (int i = 0; i < ((cur_plen > PREFIX_MAX) ? PREFIX_MAX : cur_plen); i++) begin
            pc = cur_chars[8*i +: 8];
            // a zero would end the path early; send a near miss instead
            path_buf.push_back(pc == CHAR_NUL ? 8'h01 : pc);
        end
        base = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: base = '0;
            1: base = '1;
            default: ;
        endcase
        if ($urandom_range(0, 4) != 0) base[8:0] = 9'd0;
        span = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: span = '0;
            1: span = 64'($urandom_range(1, 255));
            2: span = '1;
            default: ;
        endcase
        push_hex(64'($urandom_range(0, 255)), 2);
        path_buf.push_back(CHAR_COLON);
        push_hex(64'($urandom_range(0, 255)), 2);
        path_buf.push_back(CHAR_COLON);
        push_hex(base, 16);
        path_buf.push_back(CHAR_COLON);
        push_hex(span, 16);
        if (kind >= 65) begin
            case ($urandom_range(0, 2))
                0: path_buf[$urandom_range(0, path_buf.size() - 1)] =
                       8'($urandom_range(1, 255));
                1: begin
                    cut = $urandom_range(0, path_buf.size() - 1);
                    while (path_buf.size() > cut) void'(path_buf.pop_back());
                end
                default: repeat ($urandom_range(1, 3))
                    path_buf.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endtask

    typedef struct {
        logic [3:0]  plen;
        logic [63:0] chars;
        string       text;
        bit          typed;
        t_result     want;
    } t_row;

    t_row corner_rows[$];

    function automatic void add_row(input logic [3:0] plen, input logic [63:0] chars,
                                    input string text, input bit typed, input t_result want);
        t_row r;
        r.plen  = plen;
        r.chars = chars;
        r.text  = text;
        r.typed = typed;
        r.want  = want;
        corner_rows.push_back(r);
    endfunction

    initial begin
        logic [63:0] dev;
        logic [63:0] hd;
        logic [3:0]  plen;
        logic [63:0] chars;
        bit          late;

        dev = pack_prefix("dev/");
        hd  = pack_prefix("hd_ctrl/");

        // Corner paths; a typed answer where it is obvious, the model elsewhere
        add_row(0, '0, "00:00:0000000000000000:0000000000000001", 1,
                '{1'b1, 8'h00, 8'h00, 64'h0, 64'h1});
        add_row(0, '0, "", 1, REJECTED);
        add_row(0, '0, "ff:FF:FFFFFFFFFFFFFE00:ffffffffffffffff", 1,
                '{1'b1, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FE00, '1});
        add_row(0, '0, "12:34:0000000000000200:0000000000000000", 1, REJECTED);
        add_row(0, '0, "12:34:0000000000000201:0000000000000010", 1, REJECTED);
        add_row(0, '0, "12:34:0000000000000100:0000000000000010", 1, REJECTED);
        add_row(4, dev, "dev/0a:Bc:DEADBEEF00000000:0123456789abcdef", 0, REJECTED);
        add_row(4, dev, "dex/0a:bc:0000000000000000:0000000000000001", 1, REJECTED);
        add_row(4, dev, "dev/0a:bc:00", 1, REJECTED);
        add_row(4, dev, "dev/0a:bc:0000000000000000:0000000000000001x", 1, REJECTED);
        add_row(4, dev, "dev/0g:bc:0000000000000000:0000000000000001", 1, REJECTED);
        add_row(4, dev, "dev/0a;bc:0000000000000000:0000000000000001", 1, REJECTED);
        add_row(4, dev, "dev/", 1, REJECTED);
        add_row(4, dev, "dev/\377", 1, REJECTED);
        add_row(4, dev, "dev/9F:e7:0123456789AbCc00:FEDCBA9876543210", 0, REJECTED);
        add_row(8, hd, "hd_ctrl/01:02:0000000000001000:0000000000000100", 1,
                '{1'b1, 8'h01, 8'h02, 64'h1000, 64'h100});
        // length register above the maximum behaves as the maximum
        add_row(15, hd, "hd_ctrl/01:02:0000000000001000:0000000000000100", 1,
                '{1'b1, 8'h01, 8'h02, 64'h1000, 64'h100});
        // prefix holding a zero byte can never match
        add_row(3, pack_prefix("ab"), "ab00:00:0000000000000000:0000000000000001", 1,
                REJECTED);
        add_row(8, '1, "\377\377\377\377\377\377\377\37701:02:0000000000001000:0000000000000100",
                1, '{1'b1, 8'h01, 8'h02, 64'h1000, 64'h100});
        add_row(1, pack_prefix("/"), "/A5:5a:8000000000000000:8000000000000000", 0, REJECTED);

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (corner_rows[r]) begin
            if (corner_rows[r].plen != cur_plen || corner_rows[r].chars != cur_chars) begin
                settle();
                configure(corner_rows[r].plen, corner_rows[r].chars);
            end
            path_buf.delete();
            for (int k = 0; k < corner_rows[r].text.len(); k++)
                path_buf.push_back(corner_rows[r].text[k]);
            if (corner_rows[r].typed) typed_results.push_back(corner_rows[r].want);
            send_path();
        end

        // Hold off the receiver while short paths keep coming, so both result
        // slots fill and the character channel backs up; then pause until drained.
        settle();
        rx_hold_req = HOLD_CYCLES;
        repeat (16) begin
            path_buf.delete();
            repeat ($urandom_range(0, 3)) path_buf.push_back(8'($urandom_range(1, 255)));
            send_path();
        end
        settle();

        // Random segments; new settings only between segments, once drained
        while (chars_sent < ITEM_TARGET) begin
            late = (chars_sent >= ITEM_TARGET * 85 / 100);
            if (!late && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: plen = 4'd0;
                    1: plen = 4'(PREFIX_MAX);
                    2: plen = 4'd15;
                    default: plen = 4'($urandom_range(0, 15));
                endcase
                chars = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: chars = '1;
                    1: chars[8*$urandom_range(0, 7) +: 8] = CHAR_NUL;
                    default: ;
                endcase
                settle();
                configure(plen, chars);
            end
            // keep the tail of the run free of stalls
            tx_gaps_on = !late && ($urandom_range(0, 3) != 0);
            rx_gaps_on = !late && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 7)) begin
                if (chars_sent < ITEM_TARGET) begin
                    build_path();
                    send_path();
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d paths in %0d characters under %0d prefix settings",
                 paths_sent, chars_sent, cfg_writes);
        $display("%0d results checked, %0d recognized, %0d mismatches",
                 results_checked, recognized_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
